// ===== hdl/olt_pkg.sv =====
// Shared types and codes for the ordered list table.
`default_nettype none
package olt_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W = 4;
   localparam int OCC_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_BACK  = 2'd1,
      MODE_FIND      = 2'd2,
      MODE_DELETE    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic front;
      logic back;
      logic del;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/olt_cell.sv =====
// One list cell: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module olt_cell
   import olt_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic              valid,
   input  wire logic              tail,
   input  wire logic [DATA_W-1:0] value,
   input  wire logic [DATA_W-1:0] prev_data,
   input  wire logic [DATA_W-1:0] next_data,
   input  wire logic              hit_in,
   output logic [DATA_W-1:0]      data,
   output logic                   hit_out,
   output logic                   first
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match;

   assign match   = valid && (data_ff == value);
   assign hit_out = hit_in | match;
   assign first   = match & ~hit_in;
   assign data    = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.front) begin
         data_in = prev_data;
      end else if (ctl.back && tail) begin
         data_in = value;
      end else if (ctl.del && (hit_in || match)) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// ===== hdl/ordered_list_table_unit.sv =====
// Top level of the ordered list table: a row of cells plus count and result registers.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-------------------------
//  request | start, busy, req_mode, req_value             | taken when start && !busy
//  result  | rsp_strobe, rsp_status, rsp_position,        | one cycle, no stall
//          | rsp_occupancy                                |
//
// One item per cycle: every cell compares and shifts in the cycle the item is taken,
// and the result appears on the next cycle. busy stays low.
// The first-match search ripples through the row of cells in that same cycle.
// Reset clears the count and the result strobe; cell contents are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module ordered_list_table_unit
   import olt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [MODE_W-1:0]        req_mode,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [POS_W-1:0]              rsp_position,
   output logic [OCC_W-1:0]              rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [OCC_W-1:0]    rsp_occupancy_ff, rsp_occupancy_in;

   logic                accept;
   mode_type            mode;
   logic                full;
   logic                empty;
   logic                any_hit;
   cell_ctl_type        ctl;
   logic [DATA_W-1:0]   value;
   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic [CAPACITY:0]   hit;
   logic [CAPACITY-1:0] first;
   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] tail;
   logic [IDX_W-1:0]    hit_idx;
   logic [31:0]         pos_wide;
   logic [31:0]         occ_wide;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign mode   = mode_type'(req_mode);
   assign value  = req_value;
   assign full   = (cnt_ff == CNT_W'(CAPACITY));
   assign empty  = (cnt_ff == '0);
   assign hit[0] = 1'b0;
   assign any_hit = hit[CAPACITY];

   assign ctl.front = accept && (mode == MODE_INS_FRONT) && !full;
   assign ctl.back  = accept && (mode == MODE_INS_BACK) && !full;
   assign ctl.del   = accept && (mode == MODE_DELETE);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i] = (cnt_ff > CNT_W'(i));
      assign tail[i]  = (cnt_ff == CNT_W'(i));

      olt_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .valid     (valid[i]),
         .tail      (tail[i]),
         .value     (value),
         .prev_data ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
         .next_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
         .hit_in    (hit[i]),
         .data      (cell_data[i]),
         .hit_out   (hit[i+1]),
         .first     (first[i])
      );
   end

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_idx = hit_idx | (first[i] ? IDX_W'(i) : IDX_W'(0));
      end
   end

   always_comb begin
      cnt_in          = cnt_ff;
      rsp_status_in   = STATUS_OK;
      rsp_position_in = '0;
      pos_wide        = 32'(hit_idx);
      unique case (mode)
         MODE_INS_FRONT, MODE_INS_BACK: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         MODE_FIND: begin
            if (any_hit) begin
               rsp_position_in = pos_wide[POS_W-1:0];
            end else begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
         end
         MODE_DELETE: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else if (!any_hit) begin
               rsp_status_in = STATUS_NOT_FOUND;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      if (!accept) begin
         cnt_in = cnt_ff;
      end
      occ_wide         = 32'(cnt_in);
      rsp_occupancy_in = occ_wide[OCC_W-1:0];
      rsp_strobe_in    = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_position_ff  <= rsp_position_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule
`default_nettype wire

// ===== dv/ordered_list_table_checker.sv =====
// Checker for the ordered list table: predicts each result and compares it on arrival.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_table_checker
   import olt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     busy,
   input  wire logic [MODE_W-1:0]        req_mode,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     rsp_strobe,
   input  wire logic [STATUS_W-1:0]      rsp_status,
   input  wire logic [POS_W-1:0]         rsp_position,
   input  wire logic [OCC_W-1:0]         rsp_occupancy,
   output int                            fail_count,
   output int                            pending_count,
   output int                            checked_count
);

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [OCC_W-1:0] occupancy;
   } outcome_type;

   logic [DATA_W-1:0] entries [CAPACITY];
   int unsigned       entry_total = 0;
   outcome_type       awaited [$];
   int                fails = 0;
   int                checked = 0;

   function automatic int first_hit(logic [DATA_W-1:0] key);
      for (int i = 0; i < int'(entry_total); i++) begin
         if (entries[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic outcome_type apply_request(mode_type mode, logic [DATA_W-1:0] key);
      outcome_type res;
      int hit;
      res.status = STATUS_OK;
      res.position = '0;
      case (mode)
         MODE_INS_FRONT, MODE_INS_BACK: begin
            if (entry_total >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (mode == MODE_INS_FRONT) begin
               for (int i = int'(entry_total); i > 0; i--) begin
                  entries[i] = entries[i-1];
               end
               entries[0] = key;
               entry_total++;
            end else begin
               entries[entry_total] = key;
               entry_total++;
            end
         end
         MODE_FIND: begin
            hit = first_hit(key);
            if (hit < 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.position = POS_W'(hit);
            end
         end
         MODE_DELETE: begin
            if (entry_total == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               hit = first_hit(key);
               if (hit < 0) begin
                  res.status = STATUS_NOT_FOUND;
               end else begin
                  for (int i = hit; i + 1 < int'(entry_total); i++) begin
                     entries[i] = entries[i+1];
                  end
                  entry_total--;
               end
            end
         end
      endcase
      res.occupancy = OCC_W'(entry_total);
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         entry_total = 0;
         awaited.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: unexpected result: status %0d pos %0d occ %0d", $realtime,
                           rsp_status, rsp_position, rsp_occupancy);
               end
            end else begin
               want = awaited.pop_front();
               checked++;
               if (rsp_status !== want.status || rsp_position !== want.position ||
                   rsp_occupancy !== want.occupancy) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: mismatch: expected status %0d pos %0d occ %0d, got %0d %0d %0d",
                              $realtime, want.status, want.position, want.occupancy,
                              rsp_status, rsp_position, rsp_occupancy);
                  end
               end
            end
         end
         if (start && !busy) begin
            awaited.push_back(apply_request(mode_type'(req_mode), req_value));
         end
      end
      fail_count <= fails;
      pending_count <= awaited.size();
      checked_count <= checked;
   end

endmodule
`default_nettype wire

// ===== dv/ordered_list_table_unit_tb.sv =====
// Testbench top for the ordered list table: drives directed and random items, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_table_unit_tb;
   import olt_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 800;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [MODE_W-1:0]        req_mode = MODE_INS_FRONT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic [POS_W-1:0]         rsp_position;
   logic [OCC_W-1:0]         rsp_occupancy;
   int                       fail_count;
   int                       pending_count;
   int                       checked_count;

   int                sent_per_mode [4] = '{0, 0, 0, 0};
   logic [DATA_W-1:0] value_pool [4];

   ordered_list_table_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_position(rsp_position), .rsp_occupancy(rsp_occupancy)
   );

   ordered_list_table_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_position(rsp_position), .rsp_occupancy(rsp_occupancy),
      .fail_count(fail_count), .pending_count(pending_count),
      .checked_count(checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(mode_type mode, logic [DATA_W-1:0] value, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      do @(posedge clock); while (busy);
      sent_per_mode[mode]++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 7) begin
         return value_pool[$urandom_range(0, 3)];
      end
      return $urandom;
   endfunction

   initial begin
      bit       filling;
      int       gap_max;
      int       draw;
      mode_type mode;
      value_pool = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_FIND, 32'h0000_0001, $urandom_range(0, 12));
      send_item(MODE_DELETE, 32'h0000_0001, $urandom_range(0, 12));
      send_item(MODE_INS_FRONT, 32'h7FFF_FFFF, 0);
      send_item(MODE_INS_FRONT, 32'h8000_0000, $urandom_range(0, 12));
      send_item(MODE_INS_BACK, 32'h0000_0000, 0);
      send_item(MODE_INS_BACK, 32'hFFFF_FFFF, $urandom_range(0, 12));
      send_item(MODE_INS_BACK, 32'h7FFF_FFFF, 0);
      send_item(MODE_FIND, 32'h7FFF_FFFF, 0);
      send_item(MODE_FIND, 32'hFFFF_FFFF, $urandom_range(0, 12));
      send_item(MODE_FIND, 32'h0000_0005, 0);
      send_item(MODE_DELETE, 32'h0000_0005, 0);
      send_item(MODE_DELETE, 32'h7FFF_FFFF, $urandom_range(0, 12));
      send_item(MODE_FIND, 32'h7FFF_FFFF, 0);
      for (int i = 0; i < 12; i++) begin
         send_item(MODE_INS_BACK, 32'h0000_1000 + i, 0);
      end
      send_item(MODE_INS_FRONT, 32'h5555_5555, 0);
      send_item(MODE_INS_BACK, 32'hAAAA_AAAA, $urandom_range(0, 12));
      send_item(MODE_FIND, 32'h0000_100B, 0);
      drain_results();

      filling = 1'b0;
      gap_max = 12;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            filling = !filling;
         end
         if (n % 100 == 0) begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
         end
         if (n % 50 == 0) begin
            value_pool[$urandom_range(0, 3)] = $urandom;
         end
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end
         draw = $urandom_range(0, 99);
         if (draw < (filling ? 35 : 10)) begin
            mode = MODE_INS_FRONT;
         end else if (draw < (filling ? 70 : 20)) begin
            mode = MODE_INS_BACK;
         end else if (draw < (filling ? 85 : 45)) begin
            mode = MODE_FIND;
         end else begin
            mode = MODE_DELETE;
         end
         send_item(mode, pick_value(), $urandom_range(0, gap_max));
      end

      drain_results();
      repeat (4) @(posedge clock);
      $display("Covered %0d items: %0d insert front, %0d insert back, %0d find, %0d delete;",
               sent_per_mode.sum(), sent_per_mode[MODE_INS_FRONT], sent_per_mode[MODE_INS_BACK],
               sent_per_mode[MODE_FIND], sent_per_mode[MODE_DELETE]);
      $display("%0d results checked against prediction, %0d mismatches.", checked_count,
               fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS ordered_list_table_unit");
      end else begin
         $display("FAIL ordered_list_table_unit");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAIL ordered_list_table_unit");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/olt_pkg.sv
hdl/olt_cell.sv
hdl/ordered_list_table_unit.sv
dv/ordered_list_table_checker.sv
dv/ordered_list_table_unit_tb.sv
